FILE: sv/ist_pkg.sv
// ist_pkg: shared types and constants for the interpolation search table
// no dependencies
`default_nettype none
package ist_pkg;
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int KEY_W = 32;
   localparam int CNT_W = 11;
   localparam int POS_W = 10;
   localparam int IDX_IN_W = 10;
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;
   localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

   // controller to datapath
   typedef struct packed {
      logic init;      // load bounds for a new search
      logic rd_f;      // read K[f]
      logic rd_l;      // read K[l]
      logic cap_f;     // capture read data as K[f]
      logic cap_l;     // capture read data as K[l]
      logic mul;       // register product
      logic div_start; // start divider
      logic rd_c;      // read K[c]
      logic cap_c;     // capture K[c]
      logic step;      // narrow bounds
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;     // f > l
      logic outside;   // K[f] > key or K[l] < key
      logic div_busy;
      logic hit;
   } status_type;
endpackage
`default_nettype wire

FILE: sv/ist_divider.sv
// ist_divider: restoring divider, one quotient bit per cycle
// depends on ist_pkg
`default_nettype none
module ist_divider
   import ist_pkg::*;
#(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic [NUM_W-1:0]      quo
);
   localparam int CW = $clog2(NUM_W + 1);
   logic [CW-1:0] cnt_ff;
   logic [DEN_W:0] rem_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0] sh;
   logic [DEN_W:0] dif;

   assign sh = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
   assign dif = sh - {1'b0, den_ff};
   assign busy = (cnt_ff != '0);
   assign quo = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(NUM_W);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (start) begin
         rem_ff <= '0;
         q_ff <= num;
         den_ff <= den;
      end else if (busy) begin
         if (!dif[DEN_W]) begin
            rem_ff <= dif;
            q_ff <= {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= sh;
            q_ff <= {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

FILE: sv/ist_datapath.sv
// ist_datapath: key memory, bounds, probe arithmetic
// depends on ist_pkg and ist_divider
`default_nettype none
module ist_datapath
   import ist_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [IDX_IN_W-1:0] wr_idx,
   input  wire logic [KEY_W-1:0] in_key,
   input  wire logic [CNT_W-1:0] entry_count,
   input  wire cmd_type          cmd,
   output status_type            status,
   output logic [POS_W-1:0]      hit_pos
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int BW = AW + 2; // signed bound width
   localparam int NW = AW + KEY_W;

   logic [KEY_W-1:0] mem [TABLE_DEPTH];
   logic [KEY_W-1:0] rd_ff;
   logic signed [BW-1:0] f_ff, l_ff;
   logic [KEY_W-1:0] key_ff, kf_ff, kl_ff, kc_ff;
   logic [NW-1:0] num_ff;
   logic signed [BW-1:0] c_ff;
   logic [NW-1:0] quo;
   logic div_busy;
   logic [KEY_W-1:0] span;
   logic [AW-1:0] rd_addr;
   logic signed [BW-1:0] n_sat;
   logic signed [BW-1:0] c_raw;
   logic [NW-1:0] qclip;

   always_comb begin
      if (32'(entry_count) > TABLE_DEPTH) n_sat = BW'(TABLE_DEPTH);
      else n_sat = BW'(entry_count);
   end

   always_comb begin
      rd_addr = AW'(f_ff);
      if (cmd.rd_l) rd_addr = AW'(l_ff);
      else if (cmd.rd_c) rd_addr = AW'(c_raw);
   end

   always_ff @(posedge clock) begin
      if (wr_en && ({22'd0, wr_idx} < 32'(TABLE_DEPTH)))
         mem[AW'(wr_idx)] <= in_key;
      rd_ff <= mem[rd_addr];
   end

   assign span = kl_ff - kf_ff;
   assign qclip = quo;
   always_comb begin
      if (l_ff == f_ff || span == '0) c_raw = f_ff;
      else if (qclip > NW'(l_ff - f_ff)) c_raw = l_ff;
      else c_raw = f_ff + BW'(qclip);
   end

   ist_divider #(.NUM_W(NW), .DEN_W(KEY_W)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(num_ff + NW'(span >> 1)), .den(span),
      .busy(div_busy), .quo(quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         f_ff <= '0;
         l_ff <= n_sat - 1'b1;
         key_ff <= in_key;
      end
      if (cmd.cap_f) kf_ff <= rd_ff;
      if (cmd.cap_l) kl_ff <= rd_ff;
      if (cmd.mul) num_ff <= NW'(AW'(l_ff - f_ff)) * NW'(key_ff - kf_ff);
      if (cmd.rd_c) c_ff <= c_raw;
      if (cmd.cap_c) kc_ff <= rd_ff;
      if (cmd.step) begin
         if (key_ff < kc_ff) begin
            f_ff <= f_ff + 1'b1;
            l_ff <= c_ff - 1'b1;
         end else begin
            f_ff <= c_ff + 1'b1;
            l_ff <= l_ff - 1'b1;
         end
      end
   end

   assign status.empty = f_ff > l_ff;
   assign status.outside = (kf_ff > key_ff) || (kl_ff < key_ff);
   assign status.div_busy = div_busy;
   assign status.hit = kc_ff == key_ff;
   assign hit_pos = POS_W'(c_ff);
endmodule
`default_nettype wire

FILE: sv/ist_control.sv
// ist_control: search sequencer and result register
// depends on ist_pkg
`default_nettype none
module ist_control
   import ist_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_fire,
   input  wire logic        in_cmd,
   output logic             in_ready,
   input  wire status_type  status,
   input  wire logic [POS_W-1:0] hit_pos,
   output cmd_type          cmd,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic             out_found,
   output logic [POS_W-1:0] out_pos
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHK, S_RDF, S_RDL, S_CAPL, S_MUL, S_DIV, S_WAIT, S_RDC, S_CAPC,
      S_TEST, S_DONE
   } state_type;
   state_type state_ff, state_in;

   assign in_ready = (state_ff == S_IDLE) && !out_valid;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (in_fire && in_cmd == CMD_SEARCH) begin
            cmd.init = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.rd_f = 1'b1;
            state_in = status.empty ? S_DONE : S_RDF;
         end
         S_RDF: begin
            cmd.cap_f = 1'b1;
            cmd.rd_l = 1'b1;
            state_in = S_RDL;
         end
         S_RDL: begin
            cmd.cap_l = 1'b1;
            state_in = S_CAPL;
         end
         S_CAPL: state_in = status.outside ? S_DONE : S_MUL;
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: if (!status.div_busy) state_in = S_RDC;
         S_RDC: begin
            cmd.rd_c = 1'b1;
            state_in = S_CAPC;
         end
         S_CAPC: begin
            cmd.cap_c = 1'b1;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (status.hit) state_in = S_DONE;
            else begin
               cmd.step = 1'b1;
               state_in = S_CHK;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // set when the last probe matched the key
   logic hit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff <= (state_ff == S_TEST) && status.hit;
         if (out_valid && out_ready) out_valid <= 1'b0;
         if (state_ff == S_DONE) out_valid <= 1'b1;
      end
      if (state_ff == S_DONE) begin
         out_found <= hit_ff;
         out_pos <= hit_ff ? hit_pos : '0;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_pos));
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      in_fire |-> state_ff == S_IDLE && !out_valid);
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy);
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> state_ff == S_IDLE);
endmodule
`default_nettype wire

FILE: sv/interpolation_search_table.sv
// interpolation_search_table: top level, stream ports and csr
// depends on ist_pkg, ist_control, ist_datapath
// a write word is stored in the table as it is accepted; a search repeats a bound check
// and a probe, each probe waiting on the bit-serial divider
// one search at a time; result is held until taken
// synchronous reset clears control and entry_count; table contents undefined
`default_nettype none
module interpolation_search_table
   import ist_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // entry_index[9:0], key_value[41:10]
   input  wire logic        req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // position[9:0]
   output logic             rsp_tuser,   // found
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [CNT_W-1:0] count_ff;
   cmd_type cmd;
   status_type status;
   logic [POS_W-1:0] hit_pos, out_pos;
   logic in_fire;

   assign csr_pready = 1'b1;
   assign csr_prdata = {21'd0, count_ff};
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_ENTRY_COUNT)
         count_ff <= csr_pwdata[CNT_W-1:0];
   end

   assign in_fire = req_tvalid && req_tready;

   ist_control u_ctl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .in_cmd(req_tuser),
      .in_ready(req_tready), .status(status), .hit_pos(hit_pos), .cmd(cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_found(rsp_tuser),
      .out_pos(out_pos)
   );

   ist_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset),
      .wr_en(in_fire && req_tuser == CMD_WRITE), .wr_idx(req_tdata[9:0]),
      .in_key(req_tdata[41:10]), .entry_count(count_ff), .cmd(cmd),
      .status(status), .hit_pos(hit_pos)
   );

   assign rsp_tdata = {6'd0, out_pos};
endmodule
`default_nettype wire

FILE: tb/sv/tb_interpolation_search_table.sv
// testbench for interpolation_search_table: loads ascending key tables over the
// stream port, searches them and checks found/position against a local predictor
// depends on ist_pkg and interpolation_search_table
`timescale 1ns / 100ps
`default_nettype none
module tb_interpolation_search_table;
   import ist_pkg::*;

   typedef struct packed {
      logic        cmd;
      logic [9:0]  idx;
      logic [31:0] key;
   } req_word_type;

   typedef struct packed {
      logic       found;
      logic [9:0] pos;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [0:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   interpolation_search_table dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [31:0] keys_mirror [TABLE_DEPTH_DEF];
   int unsigned count_mirror = 0;

   req_word_type pending_words[$];
   rsp_word_type expected_hits[$];
   int unsigned errors = 0;
   bit words_done = 0;
   bit calm = 0;
   bit drv_hold = 0;
   int unsigned idle_cycles = 0;

   function automatic rsp_word_type search_table(logic [31:0] key);
      rsp_word_type r;
      int lo, hi, c;
      logic [31:0] kf, kl, kc;
      logic [63:0] span, num;
      int unsigned n;
      n = (count_mirror > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : count_mirror;
      lo = 0;
      hi = int'(n) - 1;
      r = '0;
      forever begin
         if (lo > hi) return r;
         kf = keys_mirror[lo];
         kl = keys_mirror[hi];
         if (kf > key || kl < key) return r;
         c = lo;
         if (hi != lo) begin
            span = {32'd0, kl - kf};
            if (span != 0) begin
               num = 64'(hi - lo) * {32'd0, key - kf} + (span >> 1);
               c = lo + int'(num / span);
            end
         end
         if (c < lo) c = lo;
         if (c > hi) c = hi;
         kc = keys_mirror[c];
         if (kc == key) begin
            r.found = 1'b1;
            r.pos = c[9:0];
            return r;
         end else if (key < kc) begin
            lo = lo + 1;
            hi = c - 1;
         end else begin
            lo = c + 1;
            hi = hi - 1;
         end
      end
   endfunction

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      req_word_type w;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            w = pending_words.pop_front();
            if (w.cmd == CMD_WRITE)
               keys_mirror[w.idx] = w.key;
            else
               expected_hits.push_back(search_table(w.key));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0 && !drv_hold &&
                         !(req_tvalid && req_tready && pending_words.size() == 0)) begin
               if (!calm && $urandom_range(0, 5) == 0) begin
                  req_gap <= $urandom_range(1, 13) - 1;
                  req_tvalid <= 1'b0;
               end else begin
                  w = pending_words[0];
                  req_tvalid <= 1'b1;
                  req_tuser <= w.cmd;
                  req_tdata <= {6'd0, w.key, w.idx};
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               errors++;
               $display("%0t: unexpected word expected none actual found=%0b pos=%0d",
                        $realtime, rsp_tuser, rsp_tdata[9:0]);
            end else begin
               exp_w = expected_hits.pop_front();
               if (rsp_tuser !== exp_w.found || rsp_tdata[9:0] !== exp_w.pos) begin
                  errors++;
                  $display("%0t: mismatch expected found=%0b pos=%0d actual found=%0b pos=%0d",
                           $realtime, exp_w.found, exp_w.pos, rsp_tuser, rsp_tdata[9:0]);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          csr_psel)
         idle_cycles <= 0;
      else if (!words_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == 40000) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_tvalid || expected_hits.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_entry_count(int unsigned n);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_ENTRY_COUNT;
      csr_pwdata <= n;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      count_mirror = n & 11'h7FF;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void push_word(logic cmd, logic [9:0] idx, logic [31:0] key);
      req_word_type w;
      w.cmd = cmd;
      w.idx = idx;
      w.key = key;
      pending_words.push_back(w);
   endfunction

   // loads entries 0..n-1 with a random ascending table, keys held in tbl
   task automatic load_table(int unsigned n, ref logic [31:0] tbl[$], input bit wide);
      logic [31:0] k;
      logic [31:0] step_max;
      tbl.delete();
      step_max = wide ? (32'hFFFF_FFFF / (n + 1)) : $urandom_range(1, 40);
      if (step_max == 0) step_max = 1;
      k = wide ? $urandom_range(0, step_max) : $urandom_range(0, 20);
      for (int unsigned i = 0; i < n; i++) begin
         tbl.push_back(k);
         push_word(CMD_WRITE, i[9:0], k);
         k = k + $urandom_range(1, step_max);
      end
   endtask

   task automatic search_mix(ref logic [31:0] tbl[$], input int unsigned m);
      logic [31:0] k;
      for (int unsigned i = 0; i < m; i++) begin
         if (tbl.size() != 0 && $urandom_range(0, 2) != 0)
            k = tbl[$urandom_range(0, tbl.size() - 1)];
         else if (tbl.size() != 0 && $urandom_range(0, 1) == 0)
            k = tbl[$urandom_range(0, tbl.size() - 1)] + 1;
         else
            k = $urandom;
         push_word(CMD_SEARCH, 10'($urandom), k);
      end
   endtask

   initial begin
      logic [31:0] tbl[$];
      int unsigned n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table
      push_word(CMD_SEARCH, 10'h3FF, 32'h0);
      push_word(CMD_SEARCH, 10'h000, 32'hFFFF_FFFF);
      // extreme keys, a flat run (zero divisor) and single-entry table
      push_word(CMD_WRITE, 10'd0, 32'h0);
      push_word(CMD_WRITE, 10'd1, 32'h0);
      push_word(CMD_WRITE, 10'd2, 32'h8000_0000);
      push_word(CMD_WRITE, 10'd3, 32'hFFFF_FFFF);
      push_word(CMD_WRITE, 10'd1023, 32'h5A5A_A5A5);
      wait_drained();
      set_entry_count(1);
      push_word(CMD_SEARCH, 10'd0, 32'h0);
      push_word(CMD_SEARCH, 10'd0, 32'h1);
      set_entry_count(2);
      push_word(CMD_SEARCH, 10'd0, 32'h0);
      push_word(CMD_SEARCH, 10'd0, 32'h1);
      set_entry_count(4);
      push_word(CMD_SEARCH, 10'h2AA, 32'h0);
      push_word(CMD_SEARCH, 10'h155, 32'h8000_0000);
      push_word(CMD_SEARCH, 10'd0, 32'hFFFF_FFFF);
      push_word(CMD_SEARCH, 10'd0, 32'h7FFF_FFFF);
      push_word(CMD_SEARCH, 10'd0, 32'hFFFF_FFFE);

      // random phases; small tables
      for (int ph = 0; ph < 12; ph++) begin
         n = $urandom_range(1, 24);
         if (ph == 11) calm = 1;
         wait_drained();
         set_entry_count(n);
         load_table(n, tbl, ph[0]);
         search_mix(tbl, 40);
         if (ph == 4) begin
            repeat (200) @(posedge clock);
            drv_hold = 1;
            while (req_tvalid || expected_hits.size() != 0) @(posedge clock);
            drv_hold = 0;
         end
      end
      // counts at and above the depth; only the two end entries are touched
      wait_drained();
      push_word(CMD_WRITE, 10'd0, 32'h0000_0100);
      push_word(CMD_WRITE, 10'd1023, 32'hF000_0000);
      set_entry_count(1024);
      push_word(CMD_SEARCH, 10'd0, 32'h0000_0100);
      push_word(CMD_SEARCH, 10'd0, 32'hF000_0000);
      push_word(CMD_SEARCH, 10'd0, 32'h0000_0050);
      push_word(CMD_SEARCH, 10'd0, 32'hFFFF_FFFF);
      set_entry_count(2047);
      push_word(CMD_SEARCH, 10'd0, 32'h0000_0100);
      push_word(CMD_SEARCH, 10'd0, 32'hF000_0000);
      push_word(CMD_SEARCH, 10'd0, 32'h0000_0050);
      push_word(CMD_SEARCH, 10'd0, 32'hFFFF_FFFF);
      set_entry_count(0);
      search_mix(tbl, 3);
      // out-of-range write index cannot be formed with a 10-bit index field

      wait_drained();
      words_done = 1;
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
sv/ist_pkg.sv
sv/ist_divider.sv
sv/ist_datapath.sv
sv/ist_control.sv
sv/interpolation_search_table.sv
tb/sv/tb_interpolation_search_table.sv
